[design/vector3_arithmetic_unit_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the vector arithmetic unit
// Each macro expands to a labeled concurrent assertion on clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define VECTOR3_ARITHMETIC_UNIT_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define V3AU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("v3au: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define V3AU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("v3au: next-cycle check failed");
`else
`define V3AU_ASSERT_IMP(lbl, ante, cons)
`define V3AU_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[design/v3au_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3au_pkg
// Operation codes, result modes, the pipeline word type and saturation.
// ----------------------------------------------------------------------------
package v3au_pkg;

	localparam logic [3:0] OP_ADD       = 4'd0;
	localparam logic [3:0] OP_SUB       = 4'd1;
	localparam logic [3:0] OP_SCALE     = 4'd2;
	localparam logic [3:0] OP_COMPPROD  = 4'd3;
	localparam logic [3:0] OP_CROSS     = 4'd4;
	localparam logic [3:0] OP_DOT       = 4'd5;
	localparam logic [3:0] OP_MAG       = 4'd6;
	localparam logic [3:0] OP_SQMAG     = 4'd7;
	localparam logic [3:0] OP_NORM      = 4'd8;
	localparam logic [3:0] OP_TRIM      = 4'd9;
	localparam logic [3:0] OP_CMP       = 4'd10;
	localparam logic [3:0] OP_INVERT    = 4'd11;
	localparam logic [3:0] OP_ADDSCALED = 4'd12;

	// How the final stage builds the result.
	localparam logic [1:0] MODE_FAST = 2'd0;
	localparam logic [1:0] MODE_MAG  = 2'd1;
	localparam logic [1:0] MODE_DIV  = 2'd2;

	localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [1:0]        mode;
		logic [2:0][31:0]  r;      // vector result of the early ops
		logic [31:0]       so;     // scalar result of the early ops
		logic              eq;
		logic              lt;
		logic              gt;
		logic              le;
		logic              ge;
		logic              ovf;
		logic [2:0]        neg;    // sign of each division numerator
		logic [2:0][63:0]  num;    // magnitude of each division numerator
		logic [63:0]       rad;    // square root remainder
		logic [63:0]       root;   // square root partial result
		logic [2:0][31:0]  rem;    // division remainders
		logic [2:0][31:0]  quo;    // division quotients
		logic [2:0]        big;    // quotient does not fit in 32 bits
	} item_t;

	// Saturate a wide signed value to 32 bits; the top bit flags saturation.
	function automatic logic [32:0] sat66(input logic signed [65:0] v);
		logic [32:0] res;
		if (v[65:31] == {35{v[65]}}) begin
			res = {1'b0, v[31:0]};
		end else if (v[65]) begin
			res = {1'b1, Q_MIN};
		end else begin
			res = {1'b1, Q_MAX};
		end
		return res;
	endfunction

endpackage

[design/v3au_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3au_front
// Input register, multiplier stage and result stage for all short operations.
// ----------------------------------------------------------------------------
module v3au_front import v3au_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [3:0]         operation,
	input  logic signed [31:0] ax,
	input  logic signed [31:0] ay,
	input  logic signed [31:0] az,
	input  logic signed [31:0] bx,
	input  logic signed [31:0] by,
	input  logic signed [31:0] bz,
	input  logic signed [31:0] scalar,
	output logic               out_valid,
	output item_t              out_item
);

	logic               valid_s1, valid_s2, valid_s3;
	logic [3:0]         op_s1, op_s2;
	logic signed [31:0] a_s1 [3];
	logic signed [31:0] b_s1 [3];
	logic signed [31:0] s_s1;
	logic signed [31:0] a_s2 [3];
	logic signed [31:0] b_s2 [3];
	logic signed [63:0] p_s2 [3];
	logic signed [63:0] q_s2 [3];
	logic        [63:0] sq_s2 [3];
	logic        [63:0] ss_s2;
	item_t              item_s3;

	logic signed [31:0] pa [3];
	logic signed [31:0] pb [3];
	logic signed [31:0] qa [3];
	logic signed [31:0] qb [3];

	// Stage 1: capture the word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= operation;
			a_s1[0] <= ax;
			a_s1[1] <= ay;
			a_s1[2] <= az;
			b_s1[0] <= bx;
			b_s1[1] <= by;
			b_s1[2] <= bz;
			s_s1    <= scalar;
		end
	end

	// Two shared multipliers per component; their operands follow the operation.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pa[i] = a_s1[i];
			pb[i] = b_s1[i];
			qa[i] = '0;
			qb[i] = '0;
		end
		case (op_s1)
			OP_SCALE, OP_TRIM: begin
				for (int i = 0; i < 3; i++) pb[i] = s_s1;
			end
			OP_ADDSCALED: begin
				for (int i = 0; i < 3; i++) begin
					pa[i] = b_s1[i];
					pb[i] = s_s1;
				end
			end
			OP_CROSS: begin
				pa[0] = a_s1[1]; pb[0] = b_s1[2]; qa[0] = a_s1[2]; qb[0] = b_s1[1];
				pa[1] = a_s1[2]; pb[1] = b_s1[0]; qa[1] = a_s1[0]; qb[1] = b_s1[2];
				pa[2] = a_s1[0]; pb[2] = b_s1[1]; qa[2] = a_s1[1]; qb[2] = b_s1[0];
			end
			default: begin
			end
		endcase
	end

	// Stage 2: products at full precision.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2 <= op_s1;
			for (int i = 0; i < 3; i++) begin
				a_s2[i]  <= a_s1[i];
				b_s2[i]  <= b_s1[i];
				p_s2[i]  <= 64'(pa[i]) * 64'(pb[i]);
				q_s2[i]  <= 64'(qa[i]) * 64'(qb[i]);
				sq_s2[i] <= 64'(64'(a_s1[i]) * 64'(a_s1[i]));
			end
			ss_s2 <= 64'(64'(s_s1) * 64'(s_s1));
		end
	end

	// Stage 3: sums, truncating shifts and saturation of the short operations; set-up of the long ones.
	logic signed [65:0] pw [3];
	logic signed [65:0] qw [3];
	logic signed [65:0] aw [3];
	logic signed [65:0] bw [3];
	logic signed [65:0] acc [3];
	logic signed [65:0] dot_acc;
	logic [32:0]        prod_sat [3];
	logic [32:0]        add_sat [3];
	logic [32:0]        sub_sat [3];
	logic [32:0]        inv_sat [3];
	logic [32:0]        dot_sat;
	logic [63:0]        sum_sq;
	logic [63:0]        sqm;
	logic signed [63:0] norm_num [3];
	logic signed [63:0] dnum [3];
	item_t              nx;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pw[i] = 66'(p_s2[i]);
			qw[i] = 66'(q_s2[i]);
			aw[i] = 66'(a_s2[i]);
			bw[i] = 66'(b_s2[i]);
			case (op_s2)
				OP_CROSS:     acc[i] = pw[i] - qw[i];
				OP_ADDSCALED: acc[i] = (aw[i] <<< FRAC_BITS) + pw[i];
				default:      acc[i] = pw[i];
			endcase
			prod_sat[i] = sat66(acc[i] >>> FRAC_BITS);
			add_sat[i]  = sat66(aw[i] + bw[i]);
			sub_sat[i]  = sat66(aw[i] - bw[i]);
			inv_sat[i]  = sat66(-aw[i]);
			norm_num[i] = 64'(a_s2[i]) <<< FRAC_BITS;
			dnum[i]     = (op_s2 == OP_TRIM) ? p_s2[i] : norm_num[i];
		end
		dot_acc = pw[0] + pw[1] + pw[2];
		dot_sat = sat66(dot_acc >>> FRAC_BITS);
		sum_sq  = sq_s2[0] + sq_s2[1] + sq_s2[2];
		sqm     = sum_sq >> FRAC_BITS;

		nx      = '0;
		nx.mode = MODE_FAST;
		nx.rad  = sum_sq;
		for (int i = 0; i < 3; i++) begin
			nx.neg[i] = dnum[i][63];
			nx.num[i] = dnum[i][63] ? 64'(-dnum[i]) : 64'(dnum[i]);
		end

		case (op_s2)
			OP_ADD: begin
				for (int i = 0; i < 3; i++) nx.r[i] = add_sat[i][31:0];
				nx.ovf = add_sat[0][32] | add_sat[1][32] | add_sat[2][32];
			end
			OP_SUB: begin
				for (int i = 0; i < 3; i++) nx.r[i] = sub_sat[i][31:0];
				nx.ovf = sub_sat[0][32] | sub_sat[1][32] | sub_sat[2][32];
			end
			OP_INVERT: begin
				for (int i = 0; i < 3; i++) nx.r[i] = inv_sat[i][31:0];
				nx.ovf = inv_sat[0][32] | inv_sat[1][32] | inv_sat[2][32];
			end
			OP_SCALE, OP_COMPPROD, OP_CROSS, OP_ADDSCALED: begin
				for (int i = 0; i < 3; i++) nx.r[i] = prod_sat[i][31:0];
				nx.ovf = prod_sat[0][32] | prod_sat[1][32] | prod_sat[2][32];
			end
			OP_DOT: begin
				nx.so  = dot_sat[31:0];
				nx.ovf = dot_sat[32];
			end
			OP_SQMAG: begin
				nx.so  = (|sqm[63:31]) ? Q_MAX : sqm[31:0];
				nx.ovf = |sqm[63:31];
			end
			OP_MAG: begin
				nx.mode = MODE_MAG;
			end
			OP_NORM, OP_TRIM: begin
				// A passes through unless the division path takes over.
				for (int i = 0; i < 3; i++) nx.r[i] = a_s2[i];
				if ((op_s2 == OP_NORM) ? (sum_sq != '0) : (sum_sq > ss_s2)) begin
					nx.mode = MODE_DIV;
				end
			end
			OP_CMP: begin
				nx.eq = (a_s2[0] == b_s2[0]) && (a_s2[1] == b_s2[1]) && (a_s2[2] == b_s2[2]);
				nx.lt = (a_s2[0] < b_s2[0]) && (a_s2[1] < b_s2[1]) && (a_s2[2] < b_s2[2]);
				nx.gt = (a_s2[0] > b_s2[0]) && (a_s2[1] > b_s2[1]) && (a_s2[2] > b_s2[2]);
				nx.le = (a_s2[0] <= b_s2[0]) && (a_s2[1] <= b_s2[1]) && (a_s2[2] <= b_s2[2]);
				nx.ge = (a_s2[0] >= b_s2[0]) && (a_s2[1] >= b_s2[1]) && (a_s2[2] >= b_s2[2]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s3 <= nx;
		end
	end

	assign out_valid = valid_s3;
	assign out_item  = item_s3;

endmodule

[design/v3au_sqrt_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3au_sqrt_stage
// One registered step of the digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module v3au_sqrt_stage import v3au_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  item_t in_item,
	output logic  out_valid,
	output item_t out_item
);

	localparam int SH = 62 - 2 * IDX;
	localparam logic [63:0] BIT = 64'd1 << SH;

	logic  valid_s1;
	item_t item_s1;
	item_t nx;
	logic [63:0] trial;

	always_comb begin
		nx    = in_item;
		trial = in_item.root + BIT;
		if (in_item.rad >= trial) begin
			nx.rad  = in_item.rad - trial;
			nx.root = (in_item.root >> 1) + BIT;
		end else begin
			nx.root = in_item.root >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= nx;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

[design/v3au_div_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3au_div_stage
// One registered restoring-division step for all three components.
// ----------------------------------------------------------------------------
module v3au_div_stage import v3au_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  item_t in_item,
	output logic  out_valid,
	output item_t out_item
);

	localparam int BITPOS = 31 - IDX;

	logic  valid_s1;
	item_t item_s1;
	item_t nx;
	logic [31:0] len;
	logic [31:0] base [3];
	logic [32:0] shr [3];

	always_comb begin
		nx  = in_item;
		len = in_item.root[31:0];
		for (int i = 0; i < 3; i++) begin
			// The first step starts from the upper half of the numerator.
			if (IDX == 0) begin
				base[i]   = in_item.num[i][63:32];
				nx.big[i] = in_item.num[i][63:32] >= len;
				nx.quo[i] = '0;
			end else begin
				base[i] = in_item.rem[i];
			end
			shr[i] = {base[i], in_item.num[i][BITPOS]};
			if (shr[i] >= {1'b0, len}) begin
				nx.rem[i] = 32'(shr[i] - {1'b0, len});
				nx.quo[i] = {nx.quo[i][30:0], 1'b1};
			end else begin
				nx.rem[i] = shr[i][31:0];
				nx.quo[i] = {nx.quo[i][30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= nx;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

[design/vector3_arithmetic_unit_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit_top
// Pipelined three-component Q16.16 vector ALU with saturating results.
// ----------------------------------------------------------------------------
//   channel | handshake             | payload
//   input   | in_valid / in_ready   | operation, ax..az, bx..bz, scalar
//   output  | out_valid / out_ready | rx..rz, scalar_out, five flags, overflow
//
// One word enters per cycle while in_ready is high; every word passes
// 68 registers (three front stages, 32 square root steps, 32 division
// steps and the output register). The square root and divider resolve
// one bit per stage, so they set the depth of the pipeline.
// The pipeline stalls as a whole only while its last stage holds a word and
// the output register is full and not taken; bubbles keep moving otherwise.
// Reset clears all valid bits; there is no clearing pass.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit_top import v3au_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         operation,
	input  logic signed [31:0] ax,
	input  logic signed [31:0] ay,
	input  logic signed [31:0] az,
	input  logic signed [31:0] bx,
	input  logic signed [31:0] by,
	input  logic signed [31:0] bz,
	input  logic signed [31:0] scalar,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] rx,
	output logic signed [31:0] ry,
	output logic signed [31:0] rz,
	output logic signed [31:0] scalar_out,
	output logic               all_equal,
	output logic               all_less,
	output logic               all_greater,
	output logic               all_less_equal,
	output logic               all_greater_equal,
	output logic               overflow
);

`include "vector3_arithmetic_unit_top_assert.svh"

	logic        en;
	logic        out_load;
	logic [32:0] sv;
	item_t       si [33];
	logic [32:0] dv;
	item_t       di [33];

	logic        out_valid_q;
	logic [31:0] rx_q, ry_q, rz_q, so_q;
	logic        eq_q, lt_q, gt_q, le_q, ge_q, ovf_q;

	assign out_load = !out_valid_q || out_ready;
	assign en       = out_load || !dv[32];
	assign in_ready = en;

	v3au_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.operation (operation),
		.ax        (ax),
		.ay        (ay),
		.az        (az),
		.bx        (bx),
		.by        (by),
		.bz        (bz),
		.scalar    (scalar),
		.out_valid (sv[0]),
		.out_item  (si[0])
	);

	for (genvar k = 0; k < 32; k++) begin : g_sqrt
		v3au_sqrt_stage #(.IDX(k)) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (sv[k]),
			.in_item   (si[k]),
			.out_valid (sv[k+1]),
			.out_item  (si[k+1])
		);
	end

	assign dv[0] = sv[32];
	assign di[0] = si[32];

	for (genvar k = 0; k < 32; k++) begin : g_div
		v3au_div_stage #(.IDX(k)) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (dv[k]),
			.in_item   (di[k]),
			.out_valid (dv[k+1]),
			.out_item  (di[k+1])
		);
	end

	// Final selection: quotients are signed and saturated here.
	item_t       fin;
	logic [31:0] len;
	logic [31:0] dres [3];
	logic [2:0]  dovf;
	logic [31:0] fr [3];
	logic [31:0] fso;
	logic        fovf;

	always_comb begin
		fin = di[32];
		len = fin.root[31:0];
		for (int i = 0; i < 3; i++) begin
			if (fin.neg[i]) begin
				dovf[i] = fin.big[i] || (fin.quo[i][31] && (|fin.quo[i][30:0]));
				dres[i] = dovf[i] ? Q_MIN : 32'(-fin.quo[i]);
			end else begin
				dovf[i] = fin.big[i] || fin.quo[i][31];
				dres[i] = dovf[i] ? Q_MAX : fin.quo[i];
			end
			fr[i] = fin.r[i];
		end
		fso  = fin.so;
		fovf = fin.ovf;
		case (fin.mode)
			MODE_DIV: begin
				for (int i = 0; i < 3; i++) fr[i] = dres[i];
				fovf = |dovf;
			end
			MODE_MAG: begin
				fso  = len[31] ? Q_MAX : len;
				fovf = len[31];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= dv[32];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rx_q  <= fr[0];
			ry_q  <= fr[1];
			rz_q  <= fr[2];
			so_q  <= fso;
			eq_q  <= fin.eq;
			lt_q  <= fin.lt;
			gt_q  <= fin.gt;
			le_q  <= fin.le;
			ge_q  <= fin.ge;
			ovf_q <= fovf;
		end
	end

	assign out_valid         = out_valid_q;
	assign rx                = rx_q;
	assign ry                = ry_q;
	assign rz                = rz_q;
	assign scalar_out        = so_q;
	assign all_equal         = eq_q;
	assign all_less          = lt_q;
	assign all_greater       = gt_q;
	assign all_less_equal    = le_q;
	assign all_greater_equal = ge_q;
	assign overflow          = ovf_q;

	`V3AU_ASSERT_IMP(a_stall_only_when_blocked, !in_ready, out_valid && !out_ready)
	`V3AU_ASSERT_NXT(a_last_stage_held, dv[32] && !en, dv[32])
	`V3AU_ASSERT_IMP(a_flags_no_ovf, out_valid && (all_equal || all_less || all_greater || all_less_equal || all_greater_equal), !overflow)

endmodule

[dv/vector3_arithmetic_unit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit_checker
// Watches both channels of the vector ALU, computes the expected result of
// every accepted word at full precision and compares it with each output word.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit_checker import v3au_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [3:0]         operation,
	input  logic signed [31:0] ax,
	input  logic signed [31:0] ay,
	input  logic signed [31:0] az,
	input  logic signed [31:0] bx,
	input  logic signed [31:0] by,
	input  logic signed [31:0] bz,
	input  logic signed [31:0] scalar,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] rx,
	input  logic signed [31:0] ry,
	input  logic signed [31:0] rz,
	input  logic signed [31:0] scalar_out,
	input  logic               all_equal,
	input  logic               all_less,
	input  logic               all_greater,
	input  logic               all_less_equal,
	input  logic               all_greater_equal,
	input  logic               overflow,
	output int                 fail_count,
	output int                 pending_count,
	output int                 result_count
);

	typedef struct packed {
		logic signed [31:0] x, y, z, so;
		logic eq, lt, gt, le, ge, ovf;
	} vec_result_t;

	vec_result_t expected_results[$];

	function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
			inout logic ovf);
		if (v > 128'sd2147483647) begin
			ovf = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -128'sd2147483648) begin
			ovf = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [127:0] v);
		logic [127:0] lo, hi, mid;
		lo = 0;
		hi = 128'h1_0000_0000_0000_0000;
		while (hi - lo > 1) begin
			mid = (lo + hi) >> 1;
			if (mid * mid <= v) lo = mid;
			else hi = mid;
		end
		return lo[63:0];
	endfunction

	// Division truncated toward zero, done on magnitudes.
	function automatic logic signed [127:0] div_trunc(input logic signed [127:0] n,
			input logic [127:0] d);
		logic [127:0] mag;
		mag = n < 0 ? -n : n;
		mag = mag / d;
		return n < 0 ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic vec_result_t compute_vector_op(input logic [3:0] op,
			input logic signed [31:0] a[3], input logic signed [31:0] b[3],
			input logic signed [31:0] s);
		vec_result_t res;
		logic signed [127:0] w[3];
		logic signed [127:0] sa, ss;
		logic [127:0] sum_sq, len;
		logic ovf;
		res = '0;
		ovf = 1'b0;
		sum_sq = 0;
		for (int i = 0; i < 3; i++) begin
			sa = a[i];
			sum_sq += sa * sa;
		end
		ss = s;
		for (int i = 0; i < 3; i++) w[i] = 0;
		case (op)
			OP_ADD:      for (int i = 0; i < 3; i++) w[i] = 128'(a[i]) + 128'(b[i]);
			OP_SUB:      for (int i = 0; i < 3; i++) w[i] = 128'(a[i]) - 128'(b[i]);
			OP_SCALE:    for (int i = 0; i < 3; i++) w[i] = (128'(a[i]) * ss) >>> FRAC_BITS;
			OP_COMPPROD: for (int i = 0; i < 3; i++)
				w[i] = (128'(a[i]) * 128'(b[i])) >>> FRAC_BITS;
			OP_CROSS: begin
				w[0] = (128'(a[1]) * 128'(b[2]) - 128'(a[2]) * 128'(b[1])) >>> FRAC_BITS;
				w[1] = (128'(a[2]) * 128'(b[0]) - 128'(a[0]) * 128'(b[2])) >>> FRAC_BITS;
				w[2] = (128'(a[0]) * 128'(b[1]) - 128'(a[1]) * 128'(b[0])) >>> FRAC_BITS;
			end
			OP_DOT: res.so = clamp32((128'(a[0]) * 128'(b[0]) + 128'(a[1]) * 128'(b[1])
				+ 128'(a[2]) * 128'(b[2])) >>> FRAC_BITS, ovf);
			OP_MAG:   res.so = clamp32($signed({64'd0, int_sqrt(sum_sq)}), ovf);
			OP_SQMAG: res.so = clamp32($signed(sum_sq >> FRAC_BITS), ovf);
			OP_NORM: begin
				if (sum_sq == 0) begin
					for (int i = 0; i < 3; i++) w[i] = a[i];
				end else begin
					len = int_sqrt(sum_sq);
					for (int i = 0; i < 3; i++)
						w[i] = div_trunc(128'(a[i]) <<< FRAC_BITS, len);
				end
			end
			OP_TRIM: begin
				if (sum_sq > ss * ss) begin
					len = int_sqrt(sum_sq);
					for (int i = 0; i < 3; i++) w[i] = div_trunc(128'(a[i]) * ss, len);
				end else begin
					for (int i = 0; i < 3; i++) w[i] = a[i];
				end
			end
			OP_CMP: begin
				res.eq = a[0] == b[0] && a[1] == b[1] && a[2] == b[2];
				res.lt = a[0] < b[0] && a[1] < b[1] && a[2] < b[2];
				res.gt = a[0] > b[0] && a[1] > b[1] && a[2] > b[2];
				res.le = a[0] <= b[0] && a[1] <= b[1] && a[2] <= b[2];
				res.ge = a[0] >= b[0] && a[1] >= b[1] && a[2] >= b[2];
			end
			OP_INVERT: for (int i = 0; i < 3; i++) w[i] = -128'(a[i]);
			OP_ADDSCALED: for (int i = 0; i < 3; i++)
				w[i] = ((128'(a[i]) <<< FRAC_BITS) + 128'(b[i]) * ss) >>> FRAC_BITS;
			default: ;
		endcase
		res.x = clamp32(w[0], ovf);
		res.y = clamp32(w[1], ovf);
		res.z = clamp32(w[2], ovf);
		res.ovf = ovf;
		return res;
	endfunction

	vec_result_t got, want;
	int mismatch_count;

	always @(posedge clk or negedge arst_n) begin
		logic signed [31:0] va[3], vb[3];
		if (!arst_n) begin
			fail_count <= 0;
			mismatch_count = 0;
			result_count <= 0;
			expected_results.delete();
		end else begin
			if (in_valid && in_ready) begin
				va = '{ax, ay, az};
				vb = '{bx, by, bz};
				expected_results.push_back(compute_vector_op(operation, va, vb, scalar));
			end
			if (out_valid && out_ready) begin
				got = '{rx, ry, rz, scalar_out, all_equal, all_less, all_greater,
					all_less_equal, all_greater_equal, overflow};
				result_count <= result_count + 1;
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("ERROR: unexpected output word %h", got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("ERROR: word %0d exp x=%h y=%h z=%h s=%h f=%b%b%b%b%b o=%b got x=%h y=%h z=%h s=%h f=%b%b%b%b%b o=%b",
								result_count, want.x, want.y, want.z, want.so, want.eq,
								want.lt, want.gt, want.le, want.ge, want.ovf, got.x, got.y,
								got.z, got.so, got.eq, got.lt, got.gt, got.le, got.ge, got.ovf);
					end
				end
				fail_count <= mismatch_count;
			end
		end
	end

	assign pending_count = expected_results.size();

endmodule

[dv/vector3_arithmetic_unit_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit_top_test
// Drives directed and random vector operations with random idling on both
// channels and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit_top_test;
	import v3au_pkg::*;

	localparam int RANDOM_WORDS = 850;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, out_ready = 1'b0;
	logic in_ready, out_valid;
	logic [3:0] operation = OP_ADD;
	logic signed [31:0] ax = 0, ay = 0, az = 0, bx = 0, by = 0, bz = 0, scalar = 0;
	logic signed [31:0] rx, ry, rz, scalar_out;
	logic all_equal, all_less, all_greater, all_less_equal, all_greater_equal, overflow;
	int fail_count, pending_count, result_count;
	int cycle_count = 0;
	int sent_count = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	vector3_arithmetic_unit_top dut (.*);
	vector3_arithmetic_unit_checker checker_i (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver: random stall before accepting each word.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	function automatic logic signed [31:0] pick_value(input int kind);
		case (kind)
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 0;
			3: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
			4: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_word(input logic [3:0] op, input logic signed [31:0] a0, a1,
			a2, b0, b1, b2, s, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		ax <= a0; ay <= a1; az <= a2;
		bx <= b0; by <= b1; bz <= b2;
		scalar <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_count++;
	endtask

	initial begin
		logic [3:0] op;
		logic signed [31:0] v[7];
		bit burst;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed words: every operation at the extremes, plus the special cases.
		for (int k = 0; k <= 15; k++)
			send_word(4'(k), 32'sh7fffffff, 32'sh80000000, 32'sh0001_0000,
				32'sh80000000, 32'sh7fffffff, 32'sh0002_8000, 32'sh80000000, 1'b0);
		send_word(OP_NORM, 0, 0, 0, 1, 2, 3, 4, 1'b1);
		send_word(OP_INVERT, 32'sh80000000, 5, -5, 0, 0, 0, 0, 1'b1);
		send_word(OP_TRIM, 32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0,
			-32'sh0002_0000, 1'b0);
		send_word(OP_TRIM, 32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0,
			32'sh0005_0000, 1'b0);
		send_word(OP_CMP, 1, 2, 3, 1, 2, 3, 0, 1'b0);
		send_word(OP_CMP, 1, 2, 3, 2, 3, 4, 0, 1'b0);
		send_word(OP_CMP, 5, 2, 3, 2, 1, 0, 0, 1'b0);
		send_word(OP_MAG, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0, 1'b0);
		send_word(OP_NORM, 1, 0, 0, 0, 0, 0, 0, 1'b0);
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
				: 4'($urandom_range(0, 12));
			for (int i = 0; i < 7; i++) v[i] = pick_value($urandom_range(0, 7));
			// Compare often on near-equal vectors so every flag gets exercised.
			if (op == OP_CMP && $urandom_range(0, 1)) begin
				v[3] = v[0] + $signed($urandom_range(0, 2)) - 1;
				v[4] = v[1] + $signed($urandom_range(0, 2)) - 1;
				v[5] = v[2] + $signed($urandom_range(0, 2)) - 1;
			end
			burst = (n % 100) < 20;
			send_word(op, v[0], v[1], v[2], v[3], v[4], v[5], v[6], burst);
		end
		in_valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Sent %0d words over all thirteen operations and undefined codes;",
			sent_count);
		$display("checked %0d result words with random stalls on both channels.",
			result_count);
		if (fail_count == 0 && pending_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+design
design/v3au_pkg.sv
design/v3au_front.sv
design/v3au_sqrt_stage.sv
design/v3au_div_stage.sv
design/vector3_arithmetic_unit_top.sv
dv/vector3_arithmetic_unit_checker.sv
dv/vector3_arithmetic_unit_top_test.sv
